// ----- rtl/integer_to_radix_digits_macros.svh -----
// Assertion macros shared by the integer-to-radix-digits RTL.
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ITR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itr_pkg.sv -----
// Package: constants, types and the digit glyph function of the radix converter.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

  localparam int unsigned ValueBits   = 32;
  localparam int unsigned RadixBits   = 6;
  localparam int unsigned CharBits    = 8;
  localparam int unsigned RadixMin    = 2;
  localparam int unsigned RadixMax    = 36;
  localparam int unsigned RadixDec    = 10;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned StepBits    = 4;
  localparam int unsigned DivSteps    = (ValueBits + StepBits - 1) / StepBits;
  localparam int unsigned DivBits     = DivSteps * StepBits;
  localparam int unsigned StepCntBits = (DivSteps > 1) ? $clog2(DivSteps) : 1;
  localparam int unsigned CntBits     = $clog2(ValueBits + 1);
  localparam int unsigned AddrBits    = $clog2(ValueBits);

  localparam logic [CharBits-1:0] CharZero    = 8'h30;
  localparam logic [CharBits-1:0] CharLetterA = 8'h41;
  localparam logic [CharBits-1:0] CharMinus   = 8'h2D;
  localparam logic [CharBits-1:0] CharNone    = 8'h00;

  typedef enum logic [2:0] {
    StIdle,
    StBad,
    StDiv,
    StChk,
    StSign,
    StRd,
    StPut
  } itr_state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic step;
    logic store_digit;
    logic rd;
    logic push_bad;
    logic push_sign;
    logic push_digit;
  } itr_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_bad;
    logic neg;
    logic last_step;
    logic div_done;
    logic cnt_zero;
    logic out_free;
  } itr_status_t;

  function automatic logic [CharBits-1:0] itr_glyph(input logic [RadixBits-1:0] d);
    logic [CharBits-1:0] c;
    if (d < RadixBits'(NumDigits)) begin
      c = CharZero + CharBits'(d);
    end else if (d < RadixBits'(RadixMax)) begin
      c = CharLetterA + CharBits'(d) - CharBits'(NumDigits);
    end else begin
      c = CharNone;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itr_in_if.sv -----
// Input channel: value and radix words with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface itr_in_if ();
  logic                                  valid;
  logic                                  ready;
  logic signed [itr_pkg::ValueBits-1:0]  value;
  logic        [itr_pkg::RadixBits-1:0]  radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

`default_nettype wire

// ----- rtl/itr_out_if.sv -----
// Output channel: character words with last and status flags, valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface itr_out_if ();
  logic                            valid;
  logic                            ready;
  logic [itr_pkg::CharBits-1:0]    character;
  logic                            last;
  logic                            status;

  modport source (output valid, output character, output last, output status, input ready);
  modport sink   (input valid, input character, input last, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/integer_to_radix_digits.sv -----
// Top level: signed integer to ASCII radix digits, controller plus datapath.
//
// Input channel in_i carries one word per conversion: a signed value and a radix.
// Output channel out_o returns the characters most significant first: an optional
// '-' (negative values in radix 10 only), then the digits 0-9, A-Z, with last set
// on the final word. A radix outside 2..36, or a negative value in any other radix,
// gives a single word with character 0, last 1 and status 1.
// Digits come from a restoring divider that retires 4 quotient bits per cycle;
// characters then leave from the digit memory, whose read port is registered.
// in_i.ready is high only between conversions; one word at a time is worked on.
// The output register lets the next input word be taken while the final character
// still waits. A stalled receiver holds the current character and pauses the
// sequence. Reset clears the controller, counters and output valid; the digit
// memory holds no reset and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits (
  input  logic      clk_i,
  input  logic      rst_ni,
  itr_in_if.sink    in_i,
  itr_out_if.source out_o
);

  itr_pkg::itr_cmd_t    cmd;
  itr_pkg::itr_status_t status;

  itr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  itr_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire

// ----- rtl/itr_ctrl.sv -----
// Controller: sequences load, digit division, sign and reverse digit output.
`timescale 1ns / 1ps
`default_nettype none

module itr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  itr_pkg::itr_status_t status_i,
  output itr_pkg::itr_cmd_t    cmd_o
);

  itr_pkg::itr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itr_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      itr_pkg::StIdle: begin
        if (status_i.in_valid) begin
          state_d = status_i.in_bad ? itr_pkg::StBad : itr_pkg::StDiv;
        end
      end
      itr_pkg::StBad: begin
        if (status_i.out_free) begin
          state_d = itr_pkg::StIdle;
        end
      end
      itr_pkg::StDiv: begin
        if (status_i.last_step) begin
          state_d = itr_pkg::StChk;
        end
      end
      itr_pkg::StChk: begin
        if (status_i.div_done) begin
          state_d = status_i.neg ? itr_pkg::StSign : itr_pkg::StRd;
        end else begin
          state_d = itr_pkg::StDiv;
        end
      end
      itr_pkg::StSign: begin
        if (status_i.out_free) begin
          state_d = itr_pkg::StRd;
        end
      end
      itr_pkg::StRd: begin
        state_d = itr_pkg::StPut;
      end
      itr_pkg::StPut: begin
        if (status_i.out_free) begin
          state_d = status_i.cnt_zero ? itr_pkg::StIdle : itr_pkg::StRd;
        end
      end
      default: begin
        state_d = itr_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      itr_pkg::StIdle: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = status_i.in_valid;
      end
      itr_pkg::StBad: begin
        cmd_o.push_bad = status_i.out_free;
      end
      itr_pkg::StDiv: begin
        cmd_o.step        = 1'b1;
        cmd_o.store_digit = status_i.last_step;
      end
      itr_pkg::StChk: begin
        cmd_o = '0;
      end
      itr_pkg::StSign: begin
        cmd_o.push_sign = status_i.out_free;
      end
      itr_pkg::StRd: begin
        cmd_o.rd = 1'b1;
      end
      itr_pkg::StPut: begin
        cmd_o.push_digit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/itr_dp.sv -----
// Datapath: magnitude load, radix divider, digit memory and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_macros.svh"

module itr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  itr_in_if.sink               in_i,
  itr_out_if.source            out_o,
  input  itr_pkg::itr_cmd_t    cmd_i,
  output itr_pkg::itr_status_t status_o
);

  localparam int unsigned RemBits = itr_pkg::RadixBits;

  logic [itr_pkg::DivBits-1:0]     work_q, work_d;
  logic [RemBits-1:0]              rem_q, rem_d;
  logic [itr_pkg::RadixBits-1:0]   radix_q;
  logic                            neg_q;
  logic [itr_pkg::StepCntBits-1:0] step_q;
  logic [itr_pkg::CntBits-1:0]     count_q;
  logic [RemBits-1:0]              mem_q [itr_pkg::ValueBits];
  logic [RemBits-1:0]              rd_q;
  logic [itr_pkg::AddrBits-1:0]    rd_addr;
  logic                            out_valid_q;
  logic [itr_pkg::CharBits-1:0]    char_q;
  logic                            last_q;
  logic                            status_q;

  logic [itr_pkg::ValueBits-1:0]   in_raw;
  logic [itr_pkg::ValueBits-1:0]   in_mag;
  logic                            in_neg;
  logic                            radix_ok;
  logic                            out_free;

  assign in_raw   = in_i.value;
  assign in_neg   = in_raw[itr_pkg::ValueBits-1];
  assign in_mag   = in_neg ? (~in_raw + 1'b1) : in_raw;
  assign radix_ok = in_i.radix inside {[itr_pkg::RadixMin:itr_pkg::RadixMax]};
  assign out_free = !out_valid_q || out_o.ready;
  assign rd_addr  = count_q[itr_pkg::AddrBits-1:0] - 1'b1;

  // Restoring division, StepBits quotient bits per cycle.
  always_comb begin
    logic [itr_pkg::DivBits-1:0] w;
    logic [RemBits:0]            rr;
    w  = work_q;
    rr = {1'b0, rem_q};
    for (int i = 0; i < int'(itr_pkg::StepBits); i++) begin
      rr = {rr[RemBits-1:0], w[itr_pkg::DivBits-1]};
      w  = {w[itr_pkg::DivBits-2:0], 1'b0};
      if (rr >= {1'b0, radix_q}) begin
        rr   = rr - {1'b0, radix_q};
        w[0] = 1'b1;
      end
    end
    work_d = w;
    rem_d  = rr[RemBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q  <= itr_pkg::DivBits'(in_mag);
      rem_q   <= '0;
      radix_q <= in_i.radix;
      neg_q   <= in_neg;
    end else if (cmd_i.step) begin
      work_q <= work_d;
      rem_q  <= cmd_i.store_digit ? '0 : rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.store_digit) begin
        step_q <= '0;
      end else if (cmd_i.step) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.load) begin
        count_q <= '0;
      end else if (cmd_i.store_digit) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.rd) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_digit) begin
      mem_q[count_q[itr_pkg::AddrBits-1:0]] <= rem_d;
    end
    if (cmd_i.rd) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_bad || cmd_i.push_sign || cmd_i.push_digit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_bad) begin
      char_q   <= itr_pkg::CharNone;
      last_q   <= 1'b1;
      status_q <= 1'b1;
    end else if (cmd_i.push_sign) begin
      char_q   <= itr_pkg::CharMinus;
      last_q   <= 1'b0;
      status_q <= 1'b0;
    end else if (cmd_i.push_digit) begin
      char_q   <= itr_pkg::itr_glyph(rd_q);
      last_q   <= (count_q == '0);
      status_q <= 1'b0;
    end
  end

  assign in_i.ready      = cmd_i.in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;
  assign out_o.status    = status_q;

  always_comb begin
    status_o.in_valid  = in_i.valid;
    status_o.in_bad    = !radix_ok ||
                         (in_neg && (in_i.radix != itr_pkg::RadixBits'(itr_pkg::RadixDec)));
    status_o.neg       = neg_q;
    status_o.last_step = (step_q == itr_pkg::StepCntBits'(itr_pkg::DivSteps - 1));
    status_o.div_done  = (work_q == '0) ||
                         (count_q == itr_pkg::CntBits'(itr_pkg::ValueBits));
    status_o.cnt_zero  = (count_q == '0);
    status_o.out_free  = out_free;
  end

  `ITR_ASSERT_IMP(a_cnt_range, 1'b1, count_q <= itr_pkg::CntBits'(itr_pkg::ValueBits), "digit count out of range")
  `ITR_ASSERT_IMP(a_rem_below_radix, cmd_i.step, rem_q < radix_q, "remainder not below radix")
  `ITR_ASSERT_NXT(a_store_counts, cmd_i.store_digit, count_q == $past(count_q) + 1'b1, "digit store did not advance count")
  `ITR_ASSERT_IMP(a_rd_nonempty, cmd_i.rd, count_q != '0, "digit read with empty store")
  `ITR_ASSERT_IMP(a_push_free, cmd_i.push_bad || cmd_i.push_sign || cmd_i.push_digit, !out_valid_q || out_o.ready, "push into occupied output register")

endmodule

`default_nettype wire
